@@ design/wec_pkg.sv @@
// wec_pkg: shared types and constants of the write extent coalescer.
// Depends on nothing; every design file imports it.
`timescale 1ns / 1ps

package wec_pkg;

    localparam int MAX_GROUP_DEF = 256;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLUSH = 8'd1;

    localparam logic [31:0] MAX_AGE_RST   = 32'd1000;
    localparam logic [31:0] MIN_FLUSH_RST = 32'd1048576;

    localparam int MID_DEPTH = 2;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [31:0] offset;
        logic [20:0] length;
        logic [32:0] end_pos;
        logic        expired;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [31:0] start;
        logic [32:0] size;
        logic [8:0]  members;
        logic        action;
        logic        final_res;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    a;
        result_t    b;
    } out_wr_t;

endpackage

@@ design/wec_front.sv @@
// wec_front: configuration registers, extent classification and the item queue.
// Depends on wec_pkg.
`timescale 1ns / 1ps

module wec_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [31:0]                    extent_offset,
    input  logic [20:0]                    extent_length,
    input  logic [31:0]                    extent_age,
    input  logic                           force_expire,
    input  logic                           last_in_list,
    output logic [31:0]                    min_flush_size,
    output logic                           item_valid,
    output wec_pkg::item_t                 item,
    input  logic                           item_pop
);
    import wec_pkg::*;

    logic [31:0]          max_age_reg;
    logic [31:0]          min_flush_reg;
    item_t                mem_reg [MID_DEPTH];
    logic [MID_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [MID_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [MID_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 push_hit;
    logic                 pop_hit;
    item_t                cls;

    assign cfg_ready      = 1'b1;
    assign min_flush_size = min_flush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg   <= MAX_AGE_RST;
            min_flush_reg <= MIN_FLUSH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_AGE:   max_age_reg   <= cfg_data;
                CFG_MIN_FLUSH: min_flush_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // classify: end offset and expiry
    always_comb
    begin
        cls.offset  = extent_offset;
        cls.length  = extent_length;
        cls.end_pos = {1'b0, extent_offset} + {12'd0, extent_length};
        cls.expired = force_expire | (extent_age >= max_age_reg);
        cls.last    = last_in_list;
    end

    assign full       = (cnt_reg == MID_CNT_W'(MID_DEPTH));
    assign push_hit   = push & ~full;
    assign item_valid = (cnt_reg != '0);
    assign pop_hit    = item_pop & item_valid;
    assign item       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_hit ? wr_ptr_reg + MID_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_hit ? rd_ptr_reg + MID_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + MID_CNT_W'(push_hit) - MID_CNT_W'(pop_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_hit)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ design/wec_back.sv @@
// wec_back: group tracking; closes groups and writes up to two results per extent.
// Depends on wec_pkg; fed by wec_front, drains into wec_out_queue.
`timescale 1ns / 1ps

module wec_back
#(
    parameter int MAX_GROUP = wec_pkg::MAX_GROUP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      min_flush_size,
    input  logic             item_valid,
    input  wec_pkg::item_t   item,
    output logic             item_pop,
    input  logic             out_space,
    output wec_pkg::out_wr_t out_wr
);
    import wec_pkg::*;

    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    logic             open_reg, open_next;
    logic [31:0]      begin_reg, begin_next;
    logic [32:0]      end_reg, end_next;
    logic [32:0]      size_reg, size_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             exp_reg, exp_next;

    logic             grp_open;
    logic [31:0]      grp_begin;
    logic [32:0]      grp_end;
    logic [32:0]      grp_size;
    logic [CNT_W-1:0] grp_cnt;
    logic             grp_exp;

    logic             go;
    logic             join_grp;
    logic             brk;
    logic             last_hit;
    result_t          res0;
    result_t          res1;

    assign go       = item_valid & out_space;
    assign item_pop = go;
    assign join_grp = open_reg && ({1'b0, item.offset} <= end_reg)
                      && (cnt_reg < CNT_W'(MAX_GROUP));
    assign last_hit = go & item.last;

    always_comb
    begin
        grp_open  = open_reg;
        grp_begin = begin_reg;
        grp_end   = end_reg;
        grp_size  = size_reg;
        grp_cnt   = cnt_reg;
        grp_exp   = exp_reg;
        brk       = 1'b0;
        if (go)
        begin
            if (join_grp)
            begin
                if (item.end_pos > end_reg)
                begin
                    grp_end  = item.end_pos;
                    grp_size = item.end_pos - {1'b0, begin_reg};
                end
                grp_cnt = cnt_reg + CNT_W'(1);
                grp_exp = exp_reg | item.expired;
            end
            else
            begin
                brk       = open_reg;
                grp_open  = 1'b1;
                grp_begin = item.offset;
                grp_end   = item.end_pos;
                grp_size  = {12'd0, item.length};
                grp_cnt   = CNT_W'(1);
                grp_exp   = item.expired;
            end
        end

        res0.start     = begin_reg;
        res0.size      = size_reg;
        res0.members   = 9'(cnt_reg);
        res0.action    = exp_reg | item.expired | (size_reg >= {1'b0, min_flush_size});
        res0.final_res = 1'b0;

        res1.start     = grp_begin;
        res1.size      = grp_size;
        res1.members   = 9'(grp_cnt);
        res1.action    = grp_exp;
        res1.final_res = 1'b1;

        out_wr.cnt = {1'b0, brk} + {1'b0, last_hit};
        out_wr.a   = brk ? res0 : res1;
        out_wr.b   = res1;

        // close the list: clear the group
        if (last_hit)
        begin
            open_next  = 1'b0;
            begin_next = '0;
            end_next   = '0;
            size_next  = '0;
            cnt_next   = '0;
            exp_next   = 1'b0;
        end
        else
        begin
            open_next  = grp_open;
            begin_next = grp_begin;
            end_next   = grp_end;
            size_next  = grp_size;
            cnt_next   = grp_cnt;
            exp_next   = grp_exp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            begin_reg <= '0;
            end_reg   <= '0;
            size_reg  <= '0;
            cnt_reg   <= '0;
            exp_reg   <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            begin_reg <= begin_next;
            end_reg   <= end_next;
            size_reg  <= size_next;
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_GROUP))
        else $error("group member count above limit");

    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (cnt_reg == '0 && size_reg == '0 && !exp_reg))
        else $error("closed group holds state");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        last_hit |=> !open_reg)
        else $error("group still open after list end");

    a_wr_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_wr.cnt != 2'd0) |-> go)
        else $error("result written without a consumed extent");

endmodule

@@ design/wec_out_queue.sv @@
// wec_out_queue: result queue, up to two writes and one read per cycle.
// Depends on wec_pkg; written by wec_back, read at the top-level result ports.
`timescale 1ns / 1ps

module wec_out_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  wec_pkg::out_wr_t  out_wr,
    output logic              out_space,
    output logic              empty,
    input  logic              pop,
    output wec_pkg::result_t  head
);
    import wec_pkg::*;

    result_t              mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop_hit;

    assign empty     = (cnt_reg == '0);
    assign pop_hit   = pop & ~empty;
    assign out_space = (cnt_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(out_wr.cnt);
        rd_ptr_next = pop_hit ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + OUT_CNT_W'(out_wr.cnt) - OUT_CNT_W'(pop_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= out_wr.a;
        end
        if (out_wr.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= out_wr.b;
        end
    end

endmodule

@@ design/write_extent_coalescer_top.sv @@
// write_extent_coalescer_top: top level of the write extent coalescer.
// Depends on wec_pkg, wec_front, wec_back and wec_out_queue.
//
// channel   direction  handshake               payload
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
// extents   in         push / full             extent_offset .. last_in_list
// results   out        empty / pop             group_start .. final_result
//
// One extent per cycle sustained while the result queue has room; a result
// passes the item queue entry, then the result queue write, to its ports.
// The group stage takes an extent only while the result queue has two free
// entries; full rises when the two-entry item queue fills behind it.
// Reset clears the group state and both queues at once; no clearing pass.
`timescale 1ns / 1ps

module write_extent_coalescer_top
#(
    parameter int MAX_GROUP = wec_pkg::MAX_GROUP_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [31:0]                   extent_offset,
    input  logic [20:0]                   extent_length,
    input  logic [31:0]                   extent_age,
    input  logic                          force_expire,
    input  logic                          last_in_list,
    output logic                          empty,
    input  logic                          pop,
    output logic [31:0]                   group_start,
    output logic [32:0]                   group_size,
    output logic [8:0]                    group_members,
    output logic                          action,
    output logic                          final_result
);
    import wec_pkg::*;

    logic [31:0] min_flush_size;
    logic        item_valid;
    item_t       item;
    logic        item_pop;
    logic        out_space;
    out_wr_t     out_wr;
    result_t     head;

    wec_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .extent_offset  (extent_offset),
        .extent_length  (extent_length),
        .extent_age     (extent_age),
        .force_expire   (force_expire),
        .last_in_list   (last_in_list),
        .min_flush_size (min_flush_size),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    wec_back #(.MAX_GROUP(MAX_GROUP)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_flush_size (min_flush_size),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop),
        .out_space      (out_space),
        .out_wr         (out_wr)
    );

    wec_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .out_wr    (out_wr),
        .out_space (out_space),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign group_start   = head.start;
    assign group_size    = head.size;
    assign group_members = head.members;
    assign action        = head.action;
    assign final_result  = head.final_res;

endmodule
